@@ design/lru_cache_directory_defines.svh @@
// Assertion macros shared by the cache directory modules.
`ifndef LRU_CACHE_DIRECTORY_DEFINES_SVH
`define LRU_CACHE_DIRECTORY_DEFINES_SVH

`ifndef SYNTH
// Clocked assertion that is ignored while reset is held.
`define LCD_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define LCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCD_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define LCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/lcd_pkg.sv @@
// Shared constants, transaction types and control structs of the cache directory.
package lcd_pkg;

    localparam int ENTRIES  = 8;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    localparam int KEY_W    = 64;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 3;
    localparam int FILL_W   = 4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_HIT   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EVICT = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] now;
        logic               has_dates;
    } lcd_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [FILL_W-1:0]   fill_count;
        logic                written;
    } lcd_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } lcd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;
    } lcd_stat_t;

endpackage

@@ design/lcd_datapath.sv @@
// Slot storage, sequential key and age scan, and result register of the directory.
`include "lru_cache_directory_defines.svh"

module lcd_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  lcd_pkg::lcd_cmd_t  cmd,
    output lcd_pkg::lcd_stat_t stat,
    input  lcd_pkg::lcd_req_t  s_payload,
    output lcd_pkg::lcd_rsp_t  rsp
);

    // Slot storage, undefined until written.
    logic [lcd_pkg::KEY_W-1:0]   key_mem   [lcd_pkg::ENTRIES];
    logic [lcd_pkg::STAMP_W-1:0] stamp_mem [lcd_pkg::ENTRIES];

    lcd_pkg::lcd_req_t           req_reg;
    lcd_pkg::lcd_rsp_t           rsp_reg;
    lcd_pkg::lcd_rsp_t           rsp_next;
    logic [lcd_pkg::CNT_W-1:0]   rd_ptr_reg;
    logic [lcd_pkg::CNT_W-1:0]   filled_reg;
    logic [lcd_pkg::CNT_W-1:0]   filled_next;
    logic                        cmp_vld_reg;
    logic [lcd_pkg::IDX_W-1:0]   cmp_idx_reg;
    logic [lcd_pkg::KEY_W-1:0]   rd_key_reg;
    logic [lcd_pkg::STAMP_W-1:0] rd_stamp_reg;
    logic                        hit_reg;
    logic [lcd_pkg::IDX_W-1:0]   hit_slot_reg;
    logic [lcd_pkg::STAMP_W-1:0] old_reg;
    logic [lcd_pkg::IDX_W-1:0]   victim_reg;

    logic                        issue;
    logic                        key_match;
    logic                        older;
    logic                        wr_en;
    logic [lcd_pkg::STATUS_W-1:0] res_status;
    logic [lcd_pkg::IDX_W-1:0]   res_slot;

    // A read goes out while filled slots remain and no hit has been found.
    assign issue = cmd.step && !hit_reg && (rd_ptr_reg != filled_reg);

    // Compare stage works on the registered read data.
    assign key_match = cmp_vld_reg && !hit_reg && (rd_key_reg == req_reg.key);
    assign older     = cmp_vld_reg &&
                       ((cmp_idx_reg == '0) || (rd_stamp_reg < old_reg));

    assign stat.scan_end = !cmp_vld_reg &&
                           (hit_reg || (rd_ptr_reg == filled_reg));

    // Resolve the slot: hit, next free slot, or oldest slot when full.
    always_comb begin
        if (hit_reg) begin
            res_status = lcd_pkg::STATUS_HIT;
            res_slot   = hit_slot_reg;
        end else if (filled_reg < lcd_pkg::CNT_W'(lcd_pkg::ENTRIES)) begin
            res_status = lcd_pkg::STATUS_MISS;
            res_slot   = filled_reg[lcd_pkg::IDX_W-1:0];
        end else begin
            res_status = lcd_pkg::STATUS_EVICT;
            res_slot   = victim_reg;
        end
    end

    assign wr_en       = req_reg.req_type && req_reg.has_dates;
    assign filled_next = filled_reg +
        lcd_pkg::CNT_W'(wr_en && (res_status == lcd_pkg::STATUS_MISS));

    always_comb begin
        rsp_next.status     = res_status;
        rsp_next.slot       = lcd_pkg::SLOT_W'(res_slot);
        rsp_next.fill_count = lcd_pkg::FILL_W'(filled_next);
        rsp_next.written    = wr_en;
    end

    // Slot memory: one read for the scan, one write at commit.
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_key_reg   <= key_mem[rd_ptr_reg[lcd_pkg::IDX_W-1:0]];
            rd_stamp_reg <= stamp_mem[rd_ptr_reg[lcd_pkg::IDX_W-1:0]];
        end
        if (cmd.commit && wr_en) begin
            key_mem[res_slot]   <= req_reg.key;
            stamp_mem[res_slot] <= req_reg.now;
        end
    end

    // Scan control and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            filled_reg  <= '0;
        end else begin
            cmp_vld_reg <= issue;
            if (cmd.load) begin
                rd_ptr_reg <= '0;
                hit_reg    <= 1'b0;
            end else begin
                if (issue) begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
                if (key_match) begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                filled_reg <= filled_next;
            end
        end
    end

    // Request capture, scan payload and result register.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_payload;
        end
        if (issue) begin
            cmp_idx_reg <= rd_ptr_reg[lcd_pkg::IDX_W-1:0];
        end
        if (key_match) begin
            hit_slot_reg <= cmp_idx_reg;
        end
        if (older) begin
            old_reg    <= rd_stamp_reg;
            victim_reg <= cmp_idx_reg;
        end
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    `LCD_ASSERT_ALWAYS(a_fill_bound, aclk, !aresetn || (filled_reg <= lcd_pkg::CNT_W'(lcd_pkg::ENTRIES)), "fill count above slot count")
    `LCD_ASSERT_RST(a_hit_in_range, aclk, aresetn, hit_reg |-> ({1'b0, hit_slot_reg} < filled_reg), "hit slot outside filled range")

endmodule

@@ design/lcd_ctrl.sv @@
// Controller state machine that sequences capture, scan and commit of a request.
`include "lru_cache_directory_defines.svh"

module lcd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  lcd_pkg::lcd_stat_t stat,
    output lcd_pkg::lcd_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // Next state, commands and output valid.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (stat.scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `LCD_ASSERT_RST(a_commit_free, aclk, aresetn, cmd.commit |-> out_free, "commit while result register is occupied")
    `LCD_ASSERT_RST(a_valid_from_done, aclk, aresetn, $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE), "result raised outside the commit state")

endmodule

@@ design/lru_cache_directory.sv @@
// One request at a time: after acceptance the scan reads one slot per cycle up to the fill
// count or the first key hit, then the result is committed once the output register is free.
// A new request is taken while the previous result still waits in the output register.
// Reset (aresetn low, synchronous) empties the directory and drops the result valid.
// Slot contents are not cleared; only slots below the fill count are ever read.
module lru_cache_directory (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lcd_pkg::lcd_req_t s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output lcd_pkg::lcd_rsp_t m_payload
);

    lcd_pkg::lcd_cmd_t  cmd;
    lcd_pkg::lcd_stat_t stat;

    // Sequencing of each transaction.
    lcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Slot storage, scan and result.
    lcd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_payload (s_payload),
        .rsp       (m_payload)
    );

endmodule

@@ test/lru_cache_directory_check.sv @@
`timescale 1ns / 100ps
// Checker that watches both channels of the cache directory and predicts every result.
module lru_cache_directory_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  lcd_pkg::lcd_req_t s_payload,
    input  logic              m_valid,
    input  logic              m_ready,
    input  lcd_pkg::lcd_rsp_t m_payload,
    output int                error_count,
    output int                pending_count,
    output int                result_count,
    output int                hit_count,
    output int                miss_count,
    output int                evict_count,
    output int                write_count
);

    localparam int PRINT_CAP = 100;

    // Shadow copy of the directory contents.
    logic [lcd_pkg::KEY_W-1:0]   shadow_keys   [lcd_pkg::ENTRIES];
    logic [lcd_pkg::STAMP_W-1:0] shadow_stamps [lcd_pkg::ENTRIES];
    int unsigned                 shadow_fill;

    // Responses predicted for accepted requests, oldest first.
    lcd_pkg::lcd_rsp_t lookup_rsp_q [$];

    initial begin
        error_count   = 0;
        pending_count = 0;
        result_count  = 0;
        hit_count     = 0;
        miss_count    = 0;
        evict_count   = 0;
        write_count   = 0;
        shadow_fill   = 0;
    end

    // Print one line per mismatch, up to a cap, and count every one.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    // Resolve one request against the shadow directory and apply its write.
    function automatic lcd_pkg::lcd_rsp_t resolve_request(input lcd_pkg::lcd_req_t req);
        lcd_pkg::lcd_rsp_t           rsp;
        logic                        hit;
        int unsigned                 idx;
        logic [lcd_pkg::STAMP_W-1:0] oldest;
        hit = 1'b0;
        idx = 0;
        for (int i = 0; i < shadow_fill; i++) begin
            if (!hit && shadow_keys[i] == req.key) begin
                hit = 1'b1;
                idx = i;
            end
        end
        if (hit) begin
            rsp.status = lcd_pkg::STATUS_HIT;
        end else if (shadow_fill < lcd_pkg::ENTRIES) begin
            rsp.status = lcd_pkg::STATUS_MISS;
            idx = shadow_fill;
        end else begin
            // Strict less-than scan, so the lowest index wins a tie.
            rsp.status = lcd_pkg::STATUS_EVICT;
            idx = 0;
            oldest = shadow_stamps[0];
            for (int i = 1; i < shadow_fill; i++) begin
                if (shadow_stamps[i] < oldest) begin
                    oldest = shadow_stamps[i];
                    idx = i;
                end
            end
        end
        rsp.written = 1'b0;
        if (req.req_type && req.has_dates) begin
            shadow_keys[idx]   = req.key;
            shadow_stamps[idx] = req.now;
            rsp.written = 1'b1;
            if (rsp.status == lcd_pkg::STATUS_MISS) begin
                shadow_fill++;
            end
        end
        rsp.slot       = idx[lcd_pkg::SLOT_W-1:0];
        rsp.fill_count = shadow_fill[lcd_pkg::FILL_W-1:0];
        return rsp;
    endfunction

    // Compare each result transaction first, then predict any new request.
    always @(posedge aclk) begin
        lcd_pkg::lcd_rsp_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            lookup_rsp_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (lookup_rsp_q.size() == 0) begin
                    report_mismatch("result transaction with no request outstanding");
                end else begin
                    want = lookup_rsp_q.pop_front();
                    if (m_payload.status !== want.status) begin
                        report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                            result_count, m_payload.status, want.status));
                    end
                    if (m_payload.slot !== want.slot) begin
                        report_mismatch($sformatf("result %0d: slot %0d, expected %0d",
                            result_count, m_payload.slot, want.slot));
                    end
                    if (m_payload.fill_count !== want.fill_count) begin
                        report_mismatch($sformatf("result %0d: fill_count %0d, expected %0d",
                            result_count, m_payload.fill_count, want.fill_count));
                    end
                    if (m_payload.written !== want.written) begin
                        report_mismatch($sformatf("result %0d: written %0d, expected %0d",
                            result_count, m_payload.written, want.written));
                    end
                end
                result_count++;
            end
            if (s_valid && s_ready) begin
                want = resolve_request(s_payload);
                lookup_rsp_q.push_back(want);
                case (want.status)
                    lcd_pkg::STATUS_HIT:  hit_count++;
                    lcd_pkg::STATUS_MISS: miss_count++;
                    default:              evict_count++;
                endcase
                if (want.written) begin
                    write_count++;
                end
            end
        end
        pending_count = lookup_rsp_q.size();
    end

endmodule

@@ test/lru_cache_directory_test.sv @@
`timescale 1ns / 100ps
// Top of the cache directory testbench: clock, reset, request stimulus and verdict.
module lru_cache_directory_test;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 485;
    localparam int POOL_SIZE   = 12;
    localparam int DRAIN_WAIT  = 40;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    lcd_pkg::lcd_req_t s_payload = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    lcd_pkg::lcd_rsp_t m_payload;

    int error_count;
    int pending_count;
    int result_count;
    int hit_count;
    int miss_count;
    int evict_count;
    int write_count;

    int cycle_count    = 0;
    int send_idle_pct  = 9;
    int recv_idle_pct  = 56;

    logic [lcd_pkg::KEY_W-1:0]   key_pool [POOL_SIZE];
    logic [lcd_pkg::STAMP_W-1:0] clock_now;

    lru_cache_directory i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    lru_cache_directory_check i_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload     (m_payload),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .hit_count     (hit_count),
        .miss_count    (miss_count),
        .evict_count   (evict_count),
        .write_count   (write_count)
    );

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver stalls at random according to the current profile.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one request transaction at a falling edge and hold it until accepted.
    task automatic send_req(input logic rt, input logic [lcd_pkg::KEY_W-1:0] key,
                            input logic [lcd_pkg::STAMP_W-1:0] stamp, input logic dates);
        lcd_pkg::lcd_req_t req;
        req.req_type  = rt;
        req.key       = key;
        req.now       = stamp;
        req.has_dates = dates;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_payload = req;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Random request: mostly keys from a pool larger than the directory, so hits and
    // evictions both happen, with a slowly advancing clock that often repeats stamps.
    task automatic send_random_req();
        logic [lcd_pkg::KEY_W-1:0]   key;
        logic [lcd_pkg::STAMP_W-1:0] stamp;
        int                          pick;
        if ($urandom_range(99) < 75) begin
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
            key = {$urandom, $urandom};
        end
        clock_now = clock_now + $urandom_range(3);
        pick = $urandom_range(99);
        if (pick < 8) begin
            stamp = $urandom;
        end else if (pick < 10) begin
            stamp = '0;
        end else if (pick < 12) begin
            stamp = '1;
        end else begin
            stamp = clock_now;
        end
        send_req($urandom_range(99) < 60, key, stamp, $urandom_range(99) < 85);
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        clock_now = 32'd1000;

        // Hold synchronous reset, then release it.
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: empty directory, dropped update, fill to full, hit rewrite.
        send_req(1'b0, 64'h0, 32'h0, 1'b0);
        send_req(1'b1, 64'h0, 32'h1234, 1'b0);
        send_req(1'b1, 64'h0, 32'hFFFF_FFFF, 1'b1);
        send_req(1'b0, 64'h0, 32'h0, 1'b1);
        send_req(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1);
        for (int i = 2; i < 8; i++) begin
            send_req(1'b1, 64'h0123_4567_89AB_CD00 + i, i * 100, 1'b1);
        end
        // Full: a lookup miss picks the oldest slot without writing it.
        send_req(1'b0, 64'h8000_0000_0000_0001, 32'h0, 1'b1);
        send_req(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd700, 1'b1);
        // Slot 0 becomes the oldest and must be chosen as victim.
        send_req(1'b1, 64'h0, 32'd5, 1'b1);
        send_req(1'b0, 64'h8000_0000_0000_0002, 32'h0, 1'b0);
        // Two slots share the smallest stamp; the lower index wins.
        send_req(1'b1, 64'h0, 32'd900, 1'b1);
        send_req(1'b1, 64'h0123_4567_89AB_CD03, 32'd50, 1'b1);
        send_req(1'b1, 64'h0123_4567_89AB_CD02, 32'd50, 1'b1);
        send_req(1'b1, 64'h5555_AAAA_5555_AAAA, 32'd60, 1'b0);
        send_req(1'b0, 64'h5555_AAAA_5555_AAAA, 32'd60, 1'b1);
        send_req(1'b1, 64'h5555_AAAA_5555_AAAA, 32'd1000, 1'b1);
        send_req(1'b0, 64'h5555_AAAA_5555_AAAA, 32'd0, 1'b0);

        // Random part under three idle profiles.
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_req();
        end
        send_idle_pct = 56;
        recv_idle_pct = 9;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_req();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_req();
        end
        s_valid = 1'b0;

        // Drain outstanding results, then watch for stray ones.
        while (pending_count != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("Checked %0d results: %0d hits, %0d misses, %0d evictions, %0d slot writes.",
                 result_count, hit_count, miss_count, evict_count, write_count);
        $display("Handshakes ran with sender-heavy, receiver-heavy and no idling; %0d errors.",
                 error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ lru_cache_directory.f @@
+incdir+design
design/lcd_pkg.sv
design/lcd_datapath.sv
design/lcd_ctrl.sv
design/lru_cache_directory.sv
test/lru_cache_directory_check.sv
test/lru_cache_directory_test.sv
